@@ sv/led_sign_frame_encoder_assert.svh @@
// Assertion macros for the frame encoder checker.
`ifndef LED_SIGN_FRAME_ENCODER_ASSERT_SVH
`define LED_SIGN_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define LSFE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsfe assertion failed");

// Next-cycle implication, off while reset is high.
`define LSFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsfe assertion failed");

// Next-cycle implication that also checks across reset.
`define LSFE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lsfe assertion failed");

`endif

@@ sv/lsfe_pkg.sv @@
// Types and constants for the LED sign frame encoder.
package lsfe_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_FOR_FLAG = 8'h01;
  localparam logic [7:0] ESC_FOR_ESC  = 8'h00;

  localparam logic [7:0] LOWER_FIRST = 8'd97;
  localparam logic [7:0] UPPER_FIRST = 8'd65;
  localparam logic [7:0] DIGIT_FIRST = 8'd48;
  localparam logic [7:0] ALPHA_COUNT = 8'd26;
  localparam logic [7:0] DIGIT_COUNT = 8'd10;

  // One start item expands to the flag and four payload units.
  localparam int MAX_UNITS = 5;
  localparam int CNT_W     = $clog2(MAX_UNITS + 1);

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  // A unit is one frame byte before stuffing; stuff marks bytes that get escaped.
  typedef struct packed {
    logic       err;
    logic       stuff;
    logic [7:0] data;
  } unit_t;

  typedef struct packed {
    logic                 valid;
    logic [CNT_W-1:0]     cnt;
    unit_t [MAX_UNITS-1:0] units;
  } load_t;

endpackage

@@ sv/lsfe_frame_ctl.sv @@
// Input register, frame state and expansion of one item into frame units.
module lsfe_frame_ctl import lsfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        emit_ready,
  output load_t       load
);

  logic        in_valid;
  logic [1:0]  in_kind;
  logic [39:0] in_data;

  logic [7:0] running_sum, running_sum_next;
  logic       in_frame, in_frame_next;
  logic       bad_char_seen, bad_char_seen_next;

  logic       fire;
  logic [7:0] ch;
  logic       char_ok;

  assign fire     = in_valid && emit_ready;
  assign s_tready = !in_valid || emit_ready;
  assign ch       = in_data[39:32];

  assign char_ok = (ch >= LOWER_FIRST && ch < LOWER_FIRST + ALPHA_COUNT) ||
                   (ch >= UPPER_FIRST && ch < UPPER_FIRST + ALPHA_COUNT) ||
                   (ch >= DIGIT_FIRST && ch < DIGIT_FIRST + DIGIT_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_data <= s_tdata;
    end
  end

  always_comb begin
    load               = '0;
    load.valid         = fire;
    running_sum_next   = running_sum;
    in_frame_next      = in_frame;
    bad_char_seen_next = bad_char_seen;
    unique case (kind_t'(in_kind))
      KIND_START: begin
        load.cnt            = CNT_W'(MAX_UNITS);
        load.units[0].data  = FLAG_BYTE;
        for (int i = 1; i < MAX_UNITS; i++) begin
          load.units[i].data  = in_data[8*(i-1) +: 8];
          load.units[i].stuff = 1'b1;
        end
        running_sum_next   = in_data[7:0] + in_data[15:8] + in_data[23:16] + in_data[31:24];
        in_frame_next      = 1'b1;
        bad_char_seen_next = 1'b0;
      end
      KIND_TEXT: begin
        if (in_frame && !bad_char_seen) begin
          if (char_ok) begin
            load.cnt            = CNT_W'(1);
            load.units[0].data  = ch;
            load.units[0].stuff = 1'b1;
            running_sum_next    = running_sum + ch;
          end else begin
            bad_char_seen_next = 1'b1;
          end
        end
      end
      KIND_FINISH: begin
        if (in_frame) begin
          if (bad_char_seen) begin
            load.cnt          = CNT_W'(1);
            load.units[0].err = 1'b1;
          end else begin
            load.cnt            = CNT_W'(2);
            load.units[0].data  = running_sum;
            load.units[0].stuff = 1'b1;
            load.units[1].data  = FLAG_BYTE;
          end
          running_sum_next   = '0;
          in_frame_next      = 1'b0;
          bad_char_seen_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      in_frame      <= 1'b0;
      bad_char_seen <= 1'b0;
    end else if (fire) begin
      running_sum   <= running_sum_next;
      in_frame      <= in_frame_next;
      bad_char_seen <= bad_char_seen_next;
    end
  end

endmodule

@@ sv/lsfe_stuffer.sv @@
// Unit buffer and output register stage that escapes flag and escape bytes.
module lsfe_stuffer import lsfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  load_t      load,
  output logic       emit_ready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic       m_tuser
);

  unit_t [MAX_UNITS-1:0] units;
  logic [CNT_W-1:0]      cnt;
  logic                  phase;

  unit_t cur;
  logic  esc;
  logic  beat;

  assign cur  = units[0];
  assign esc  = cur.stuff && (cur.data == FLAG_BYTE || cur.data == ESC_BYTE);
  assign beat = m_tvalid && m_tready;

  assign m_tvalid = (cnt != '0);
  assign m_tlast  = (cnt == CNT_W'(1)) && (!esc || phase);
  assign m_tuser  = cur.err;

  always_comb begin
    if (!esc) begin
      m_tdata = cur.data;
    end else if (!phase) begin
      m_tdata = ESC_BYTE;
    end else begin
      m_tdata = (cur.data == FLAG_BYTE) ? ESC_FOR_FLAG : ESC_FOR_ESC;
    end
  end

  // Free for a new load when empty or when the final byte leaves this cycle.
  assign emit_ready = !m_tvalid || (beat && m_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      phase <= 1'b0;
    end else if (load.valid) begin
      cnt   <= load.cnt;
      phase <= 1'b0;
    end else if (beat) begin
      if (esc && !phase) begin
        phase <= 1'b1;
      end else begin
        phase <= 1'b0;
        cnt   <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      units <= load.units;
    end else if (beat && (!esc || phase)) begin
      for (int i = 0; i < MAX_UNITS - 1; i++) begin
        units[i] <= units[i+1];
      end
    end
  end

endmodule

@@ sv/led_sign_frame_encoder.sv @@
// Top level of the LED sign frame encoder.
//   channel   dir  payload
//   s_*       in   tdata: frame_id, colour, display_mode, speed, character; tuser: kind
//   m_*       out  tdata: out_byte; tlast: run_last; tuser: frame_error
// An item waits in the input register, then expands into units that the output
// stage sends at one byte per cycle while m_tready is high: a text character gives
// 1 or 2 bytes, a finish 1 to 3, a start 5 to 9; dropped items give none.
// The output byte rate, set by the stuffing stage, bounds throughput.
// Synchronous reset clears the frame state and empties both stages.
// A stalled m_tready holds the current byte; s_tready drops once the input
// register holds an item that the output stage cannot yet take.
module led_sign_frame_encoder import lsfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // frame_id, colour, display_mode, speed, character
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,
  output logic        m_tuser    // frame_error
);

  load_t load;
  logic  emit_ready;

  lsfe_frame_ctl u_ctl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .emit_ready (emit_ready),
    .load       (load)
  );

  lsfe_stuffer u_stuff (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .emit_ready (emit_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

@@ sv/lsfe_checker.sv @@
// Port-level checks for the LED sign frame encoder, bound to the top level.
`include "led_sign_frame_encoder_assert.svh"

module lsfe_checker import lsfe_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // An error marker is always a lone zero byte ending its run.
  `LSFE_ASSERT_NOW(err_is_last, clk, rst, m_tvalid && m_tuser, m_tlast && m_tdata == 8'h00)

  // Reset empties the output stage and opens the input.
  `LSFE_ASSERT_NEXT_ALWAYS(rst_clears, clk, rst, !m_tvalid && s_tready)

  // A stalled byte holds.
  `LSFE_ASSERT_NEXT(out_hold, clk, rst, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

  // An escape byte is never the end of a run.
  `LSFE_ASSERT_NOW(esc_not_last, clk, rst, m_tvalid && m_tdata == ESC_BYTE && !m_tuser, !m_tlast)

endmodule

bind led_sign_frame_encoder lsfe_checker u_lsfe_checker (.*);

@@ tb/tb_led_sign_frame_encoder.sv @@
// Self-checking testbench for the LED sign frame encoder: directed table, then random frames.
module tb_led_sign_frame_encoder;
  import lsfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int USEFUL_TARGET = 440;  // items that move the encoder
  localparam int CALM_ITEMS    = 60;   // tail of the run without idling
  localparam int LONG_HOLD     = 300;  // cycles the sink blocks once
  localparam int DRAIN_LIMIT   = 20000;
  localparam int N_DIR         = 24;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      id;
    logic [7:0]      colour;
    logic [7:0]      mode;
    logic [7:0]      speed;
    logic [7:0]      chr;
    logic            typed;        // expected bytes below replace the prediction
    logic [1:0]      n_typed;
    logic [0:2][7:0] typed_bytes;
    logic            typed_err;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } frame_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  // predictor state
  logic [7:0] frm_sum  = '0;
  logic       frm_open = 1'b0;
  logic       frm_bad  = 1'b0;

  frame_out_t scratch_q[$];
  frame_out_t frame_bytes_q[$];

  int  mismatches  = 0;
  int  useful_sent = 0;
  int  rx_gap      = 0;
  bit  idle_en     = 1'b0;
  bit  hold_go     = 1'b0;
  bit  hold_on     = 1'b0;

  led_sign_frame_encoder u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 100) begin
      $display("ERROR at %0t: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic void put_raw(input logic [7:0] b);
    frame_out_t e;
    e = '{b, 1'b0, 1'b0};
    scratch_q.insert(scratch_q.size(), e);
  endfunction

  function automatic void put_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE) begin
      put_raw(ESC_BYTE);
      put_raw(ESC_FOR_FLAG);
    end else if (b == ESC_BYTE) begin
      put_raw(ESC_BYTE);
      put_raw(ESC_FOR_ESC);
    end else begin
      put_raw(b);
    end
  endfunction

  function automatic void put_payload(input logic [7:0] b);
    frm_sum = frm_sum + b;
    put_stuffed(b);
  endfunction

  // Expands one accepted item into the bytes it should produce (left in scratch_q).
  function automatic void encode_item(input stim_row_t it);
    logic alnum;
    frame_out_t e;
    scratch_q.delete();
    case (it.kind)
      KIND_START: begin
        frm_sum  = '0;
        frm_bad  = 1'b0;
        frm_open = 1'b1;
        put_raw(FLAG_BYTE);
        put_payload(it.id);
        put_payload(it.colour);
        put_payload(it.mode);
        put_payload(it.speed);
      end
      KIND_TEXT: begin
        if (frm_open && !frm_bad) begin
          alnum = (it.chr >= LOWER_FIRST && it.chr < LOWER_FIRST + ALPHA_COUNT) ||
                  (it.chr >= UPPER_FIRST && it.chr < UPPER_FIRST + ALPHA_COUNT) ||
                  (it.chr >= DIGIT_FIRST && it.chr < DIGIT_FIRST + DIGIT_COUNT);
          if (alnum) put_payload(it.chr);
          else frm_bad = 1'b1;
        end
      end
      KIND_FINISH: begin
        if (frm_open) begin
          if (frm_bad) begin
            e = '{8'h00, 1'b0, 1'b1};
            scratch_q.insert(scratch_q.size(), e);
          end else begin
            put_stuffed(frm_sum);
            put_raw(FLAG_BYTE);
          end
          frm_open = 1'b0;
          frm_bad  = 1'b0;
          frm_sum  = '0;
        end
      end
      default: ;
    endcase
    if (scratch_q.size() != 0) scratch_q[scratch_q.size()-1].last = 1'b1;
  endfunction

  // Called at a falling edge; returns at a falling edge after the item is taken.
  task automatic send_item(input stim_row_t it);
    int gap;
    frame_out_t e;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.chr, it.speed, it.mode, it.colour, it.id};
    s_tuser  <= it.kind;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    encode_item(it);
    if (scratch_q.size() != 0) useful_sent++;
    if (it.typed) begin
      for (int i = 0; i < it.n_typed; i++) begin
        e = '{it.typed_bytes[i], i == it.n_typed - 1, it.typed_err};
        frame_bytes_q.insert(frame_bytes_q.size(), e);
      end
    end else begin
      foreach (scratch_q[i]) frame_bytes_q.insert(frame_bytes_q.size(), scratch_q[i]);
    end
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    logic [7:0] odd [6] = '{8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B};
    if ($urandom_range(0, 11) == 0) begin
      // mostly the neighbors of the legal ranges
      if ($urandom_range(0, 1) == 0) return odd[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 2))
      0: return DIGIT_FIRST + 8'($urandom_range(0, DIGIT_COUNT - 1));
      1: return UPPER_FIRST + 8'($urandom_range(0, ALPHA_COUNT - 1));
      default: return LOWER_FIRST + 8'($urandom_range(0, ALPHA_COUNT - 1));
    endcase
  endfunction

  // Unused fields stay random so every input bit toggles.
  function automatic stim_row_t rand_row(input logic [1:0] kind);
    stim_row_t r;
    r = '0;
    r.kind   = kind;
    r.id     = 8'($urandom);
    r.colour = 8'($urandom);
    r.mode   = 8'($urandom);
    r.speed  = 8'($urandom);
    r.chr    = 8'($urandom);
    return r;
  endfunction

  // sink side: short random stalls, plus the one long hold-off
  always @(negedge clk) begin
    if (hold_on) begin
      m_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      m_tready <= 1'b0;
      rx_gap   <= rx_gap - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      rx_gap   <= $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin : long_hold
    wait (hold_go);
    @(negedge clk);
    hold_on <= 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin : byte_check
    frame_out_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (frame_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", m_tdata));
      end else begin
        want = frame_bytes_q.pop_front();
        if (m_tdata !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("run_last %b, want %b", m_tlast, want.last));
        if (m_tuser !== want.err)
          report_mismatch($sformatf("frame_error %b, want %b", m_tuser, want.err));
      end
    end
  end

  initial begin : stimulus
    stim_row_t dir_rows [N_DIR];
    stim_row_t row;
    int n_text;
    int waited;

    dir_rows = '{
      // outside a frame nothing comes out
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_FINISH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      // all-zero header, checksum 00
      '{KIND_START,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_FINISH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 2'd2, '{8'h00, 8'h7E, 8'h00}, 1'b0},
      // header bytes that need escaping, then the edges of every legal range
      '{KIND_START,  8'h7E, 8'h7D, 8'hFF, 8'h01, 8'h00, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h30, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h39, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h5A, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h61, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h7A, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_FINISH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      // checksum equal to the flag gets escaped
      '{KIND_START,  8'h7E, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_FINISH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 2'd3, '{8'h7D, 8'h01, 8'h7E}, 1'b0},
      // bad character, text after it dropped, finish flags the error
      '{KIND_START,  8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h2F, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_FINISH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 2'd1, '{8'h00, 8'h00, 8'h00}, 1'b1},
      // restart inside an errored frame, then another bad character; finish flags the error
      '{KIND_START,  8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h00, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h3A, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_START,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_TEXT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h7B, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}, 1'b0},
      '{KIND_FINISH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 2'd1, '{8'h00, 8'h00, 8'h00}, 1'b1}
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_item(dir_rows[i]);
    end

    useful_sent = 0;
    while (useful_sent < USEFUL_TARGET) begin
      idle_en = (useful_sent < USEFUL_TARGET - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      if (!hold_go && useful_sent > 150) hold_go = 1'b1;

      // stray items between frames
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(rand_row(KIND_TEXT));
          1: send_item(rand_row(KIND_FINISH));
          default: send_item(rand_row(KIND_UNUSED));
        endcase
      end

      row = rand_row(KIND_START);
      row.id     = pick_byte();
      row.colour = pick_byte();
      row.mode   = pick_byte();
      row.speed  = pick_byte();
      send_item(row);

      n_text = $urandom_range(0, 8);
      for (int k = 0; k < n_text; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(rand_row(KIND_UNUSED));
        end else begin
          row = rand_row(KIND_TEXT);
          row.chr = pick_char();
          send_item(row);
        end
      end

      // now and then leave the frame open so the next start abandons it
      if ($urandom_range(0, 9) != 0) send_item(rand_row(KIND_FINISH));
    end

    s_tvalid <= 1'b0;
    waited = 0;
    while (frame_bytes_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (frame_bytes_q.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", frame_bytes_q.size()));

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
